// ===== design/wpn_pkg.sv =====
// Shared constants, codes, control word type and microcode for the noise generator.
package wpn_pkg;

	localparam int SAMPLE_BITS_DEF = 24;
	localparam int ACC_BITS_DEF    = 40;
	localparam int GEN_BITS        = 32;
	localparam int ACC_FRAC        = 24;
	localparam int COEF_FRAC       = 30;
	localparam int COEF_BITS       = 31;

	localparam logic [GEN_BITS-1:0] SEED_FALLBACK = 32'h1234_5678;

	// configuration register indexes
	localparam int CFG_IDX_BITS = 2;
	localparam logic [CFG_IDX_BITS-1:0] CFG_MODE = 2'd0;
	localparam logic [CFG_IDX_BITS-1:0] CFG_SEED = 2'd1;

	// coefficient selects
	localparam logic [2:0] CF_SLOW_POLE = 3'd0;
	localparam logic [2:0] CF_SLOW_IN   = 3'd1;
	localparam logic [2:0] CF_MID_POLE  = 3'd2;
	localparam logic [2:0] CF_MID_IN    = 3'd3;
	localparam logic [2:0] CF_FAST_POLE = 3'd4;
	localparam logic [2:0] CF_FAST_IN   = 3'd5;
	localparam logic [2:0] CF_DIRECT    = 3'd6;
	localparam logic [2:0] CF_GAIN      = 3'd7;

	// multiplier operand selects
	localparam logic [2:0] OPD_SLOW = 3'd0;
	localparam logic [2:0] OPD_MID  = 3'd1;
	localparam logic [2:0] OPD_FAST = 3'd2;
	localparam logic [2:0] OPD_W    = 3'd3;
	localparam logic [2:0] OPD_SUM  = 3'd4;

	// retire operations, applied to the product issued by an earlier step
	localparam logic [2:0] RET_NONE      = 3'd0;
	localparam logic [2:0] RET_LOAD_T    = 3'd1;
	localparam logic [2:0] RET_SAT_SLOW  = 3'd2;
	localparam logic [2:0] RET_SAT_MID   = 3'd3;
	localparam logic [2:0] RET_SAT_FAST  = 3'd4;
	localparam logic [2:0] RET_SUM       = 3'd5;
	localparam logic [2:0] RET_OUT_PINK  = 3'd6;
	localparam logic [2:0] RET_OUT_WHITE = 3'd7;

	localparam int PC_BITS = 4;
	localparam logic [PC_BITS-1:0] PC_WHITE = 4'd13;

	typedef struct packed {
		logic       jmp_white;
		logic       issue;
		logic [2:0] opnd;
		logic [2:0] coef;
		logic [2:0] ret;
		logic       done;
	} ctrl_t;

	function automatic logic [COEF_BITS-1:0] coef_rom(input logic [2:0] sel);
		logic [COEF_BITS-1:0] c;
		case (sel)
			CF_SLOW_POLE: c = 31'd1071218531;
			CF_SLOW_IN:   c = 31'd106349833;
			CF_MID_POLE:  c = 31'd1034013377;
			CF_MID_IN:    c = 31'd318382060;
			CF_FAST_POLE: c = 31'd612032840;
			CF_FAST_IN:   c = 31'd1130318677;
			CF_DIRECT:    c = 31'd198427489;
			CF_GAIN:      c = 31'd193273528;
			default:      c = '0;
		endcase
		return c;
	endfunction

	function automatic ctrl_t cw(input logic jw, input logic iss, input logic [2:0] opnd,
			input logic [2:0] coef, input logic [2:0] ret, input logic done);
		ctrl_t w;
		w.jmp_white = jw;
		w.issue     = iss;
		w.opnd      = opnd;
		w.coef      = coef;
		w.ret       = ret;
		w.done      = done;
		return w;
	endfunction

	// program: filters pole-then-input, sum, gain; white mode branches out at step 0
	function automatic ctrl_t prog(input logic [PC_BITS-1:0] pc);
		ctrl_t w;
		case (pc)
			4'd0:  w = cw(1'b1, 1'b0, OPD_W,    CF_SLOW_POLE, RET_NONE,      1'b0);
			4'd1:  w = cw(1'b0, 1'b1, OPD_SLOW, CF_SLOW_POLE, RET_NONE,      1'b0);
			4'd2:  w = cw(1'b0, 1'b1, OPD_W,    CF_SLOW_IN,   RET_NONE,      1'b0);
			4'd3:  w = cw(1'b0, 1'b1, OPD_MID,  CF_MID_POLE,  RET_LOAD_T,    1'b0);
			4'd4:  w = cw(1'b0, 1'b1, OPD_W,    CF_MID_IN,    RET_SAT_SLOW,  1'b0);
			4'd5:  w = cw(1'b0, 1'b1, OPD_FAST, CF_FAST_POLE, RET_LOAD_T,    1'b0);
			4'd6:  w = cw(1'b0, 1'b1, OPD_W,    CF_FAST_IN,   RET_SAT_MID,   1'b0);
			4'd7:  w = cw(1'b0, 1'b1, OPD_W,    CF_DIRECT,    RET_LOAD_T,    1'b0);
			4'd8:  w = cw(1'b0, 1'b0, OPD_W,    CF_DIRECT,    RET_SAT_FAST,  1'b0);
			4'd9:  w = cw(1'b0, 1'b0, OPD_W,    CF_DIRECT,    RET_SUM,       1'b0);
			4'd10: w = cw(1'b0, 1'b1, OPD_SUM,  CF_GAIN,      RET_NONE,      1'b0);
			4'd11: w = cw(1'b0, 1'b0, OPD_SUM,  CF_GAIN,      RET_NONE,      1'b0);
			4'd12: w = cw(1'b0, 1'b0, OPD_SUM,  CF_GAIN,      RET_OUT_PINK,  1'b1);
			4'd13: w = cw(1'b0, 1'b0, OPD_W,    CF_GAIN,      RET_OUT_WHITE, 1'b1);
			default: w = cw(1'b0, 1'b0, OPD_W,  CF_GAIN,      RET_NONE,      1'b1);
		endcase
		return w;
	endfunction

endpackage

// ===== design/wpn_cmul.sv =====
// Two-stage sign-magnitude coefficient multiplier, truncating toward zero.
module wpn_cmul #(
	parameter int ACC_BITS = wpn_pkg::ACC_BITS_DEF,
	localparam int OP_W  = ACC_BITS + 2,
	localparam int RES_W = OP_W + wpn_pkg::COEF_BITS - wpn_pkg::COEF_FRAC + 2
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              issue,
	input  logic signed [OP_W-1:0]            opnd,
	input  logic [wpn_pkg::COEF_BITS-1:0]     coef,
	output logic                              res_valid,
	output logic signed [RES_W-1:0]           res
);
	import wpn_pkg::*;

	localparam int HI_BITS  = OP_W - ACC_FRAC;
	localparam int PH_W     = HI_BITS + COEF_BITS;
	localparam int PL_W     = ACC_FRAC + COEF_BITS;
	localparam int HI_SHIFT = COEF_FRAC - ACC_FRAC;
	localparam int RW       = PH_W - HI_SHIFT + 1;

	logic [OP_W-1:0]  mag;
	logic             neg;
	logic [PH_W-1:0]  ph_s1;
	logic [PL_W-1:0]  pl_s1;
	logic             neg_s1;
	logic             v_s1;
	logic [PL_W:0]    low_sum;
	logic [RW-1:0]    r;
	logic             v_s2;
	logic signed [RES_W-1:0] res_s2;

	assign neg = opnd[OP_W-1];
	assign mag = neg ? (~opnd + 1'b1) : opnd;

	always_ff @(posedge clk) begin
		if (issue) begin
			ph_s1  <= PH_W'(mag[OP_W-1:ACC_FRAC]) * PH_W'(coef);
			pl_s1  <= PL_W'(mag[ACC_FRAC-1:0]) * PL_W'(coef);
			neg_s1 <= neg;
		end
	end

	// floor(m*c / 2^30) from the split products
	assign low_sum = {1'b0, pl_s1} + (PL_W+1)'({ph_s1[HI_SHIFT-1:0], {ACC_FRAC{1'b0}}});
	assign r = RW'(ph_s1 >> HI_SHIFT) + RW'(low_sum >> COEF_FRAC);

	always_ff @(posedge clk) begin
		if (v_s1)
			res_s2 <= neg_s1 ? -$signed({1'b0, r}) : $signed({1'b0, r});
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
		end else begin
			v_s1 <= issue;
			v_s2 <= v_s1;
		end
	end

	assign res_valid = v_s2;
	assign res       = res_s2;

endmodule

// ===== design/white_pink_noise_generator.sv =====
// Each accepted item runs the microcode program, and its word is registered on the done step.
// One item at a time: white mode runs steps 0 and 13; pink mode runs steps 0 to 12,
// stepping eight products through the one two-stage multiplier.
// A finished word waits in the output register while the next item is taken.
// Reset: mode white, seed 0x12345678, generator loaded with the seed, filters cleared.
module white_pink_noise_generator #(
	parameter int SAMPLE_BITS = wpn_pkg::SAMPLE_BITS_DEF,
	parameter int ACC_BITS    = wpn_pkg::ACC_BITS_DEF
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                item_valid,
	output logic                                item_stall,
	input  logic                                restart,
	output logic                                result_valid,
	input  logic                                result_stall,
	output logic signed [SAMPLE_BITS-1:0]       sample,
	input  logic                                cfg_valid,
	output logic                                cfg_ready,
	input  logic [wpn_pkg::CFG_IDX_BITS-1:0]    cfg_index,
	input  logic [wpn_pkg::GEN_BITS-1:0]        cfg_data
);
	import wpn_pkg::*;

	localparam int OP_W  = ACC_BITS + 2;
	localparam int RES_W = OP_W + COEF_BITS - COEF_FRAC + 2;
	localparam int W_W   = GEN_BITS - (31 - ACC_FRAC);
	localparam int DROP  = (SAMPLE_BITS - 1 <= ACC_FRAC) ? ACC_FRAC - (SAMPLE_BITS - 1) : 0;
	localparam int ADD   = (SAMPLE_BITS - 1 > ACC_FRAC) ? (SAMPLE_BITS - 1) - ACC_FRAC : 0;
	localparam int SC_W  = RES_W + ADD;

	logic                     mode_q;
	logic [GEN_BITS-1:0]      seed_q;
	logic [GEN_BITS-1:0]      gen_q;
	logic signed [ACC_BITS-1:0] slow_q, mid_q, fast_q;
	logic signed [RES_W-1:0]  t_q;
	logic signed [OP_W-1:0]   sum_q;
	logic                     busy_q;
	logic [PC_BITS-1:0]       pc_q;
	logic                     result_valid_q;
	logic signed [SAMPLE_BITS-1:0] sample_q;

	ctrl_t                    word;
	logic                     accept, cfg_wr, out_free, advance;
	logic [GEN_BITS-1:0]      seed_eff, gen_src, x1, x2, x3, gen_next, wr_seed_eff;
	logic signed [W_W-1:0]    w;
	logic                     mul_issue, mul_valid;
	logic signed [OP_W-1:0]   mul_opnd;
	logic signed [RES_W-1:0]  mul_res;
	logic signed [RES_W:0]    sat_in, acc_max, acc_min;
	logic signed [ACC_BITS-1:0] sat_val;
	logic signed [OP_W-1:0]   sum_d;
	logic signed [SC_W-1:0]   p_ext, scaled, smax, smin;
	logic signed [SAMPLE_BITS-1:0] pink_val, white_val, out_val;

	assign word     = prog(pc_q);
	assign accept   = item_valid && !item_stall;
	assign cfg_wr   = cfg_valid && cfg_ready;
	assign out_free = !result_valid_q || !result_stall;
	assign advance  = busy_q && (!word.done || out_free);

	assign item_stall   = busy_q;
	// register writes only while idle and no item is on offer
	assign cfg_ready    = !busy_q && !item_valid;
	assign result_valid = result_valid_q;
	assign sample       = sample_q;

	// xorshift 13/17/5 with zero fallback
	assign seed_eff    = (seed_q == '0) ? SEED_FALLBACK : seed_q;
	assign wr_seed_eff = (cfg_data == '0) ? SEED_FALLBACK : cfg_data;
	assign gen_src     = restart ? seed_eff : gen_q;
	assign x1          = gen_src ^ (gen_src << 13);
	assign x2          = x1 ^ (x1 >> 17);
	assign x3          = x2 ^ (x2 << 5);
	assign gen_next    = (x3 == '0) ? SEED_FALLBACK : x3;

	assign w = $signed(gen_q[GEN_BITS-1 -: W_W]);

	assign mul_issue = busy_q && word.issue;

	always_comb begin
		case (word.opnd)
			OPD_SLOW: mul_opnd = OP_W'(slow_q);
			OPD_MID:  mul_opnd = OP_W'(mid_q);
			OPD_FAST: mul_opnd = OP_W'(fast_q);
			OPD_W:    mul_opnd = OP_W'(w);
			OPD_SUM:  mul_opnd = sum_q;
			default:  mul_opnd = '0;
		endcase
	end

	wpn_cmul #(.ACC_BITS(ACC_BITS)) u_cmul (
		.clk       (clk),
		.arst_n    (arst_n),
		.issue     (mul_issue),
		.opnd      (mul_opnd),
		.coef      (coef_rom(word.coef)),
		.res_valid (mul_valid),
		.res       (mul_res)
	);

	// pole term plus input term, clamped to the accumulator range
	assign sat_in  = (RES_W+1)'(t_q) + (RES_W+1)'(mul_res);
	assign acc_max = {{(RES_W+2-ACC_BITS){1'b0}}, {(ACC_BITS-1){1'b1}}};
	assign acc_min = ~acc_max;
	assign sat_val = (sat_in > acc_max) ? acc_max[ACC_BITS-1:0] :
			(sat_in < acc_min) ? acc_min[ACC_BITS-1:0] : sat_in[ACC_BITS-1:0];

	assign sum_d = OP_W'(slow_q) + OP_W'(mid_q) + OP_W'(fast_q) + $signed(mul_res[OP_W-1:0]);

	assign p_ext    = SC_W'(mul_res);
	assign scaled   = (p_ext >>> DROP) <<< ADD;
	assign smax     = {{(SC_W-SAMPLE_BITS+1){1'b0}}, {(SAMPLE_BITS-1){1'b1}}};
	assign smin     = ~smax;
	assign pink_val = (scaled > smax) ? smax[SAMPLE_BITS-1:0] :
			(scaled < smin) ? smin[SAMPLE_BITS-1:0] : scaled[SAMPLE_BITS-1:0];
	assign white_val = $signed(gen_q[GEN_BITS-1 -: SAMPLE_BITS]);
	assign out_val   = (word.ret == RET_OUT_PINK) ? pink_val : white_val;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q         <= 1'b0;
			seed_q         <= SEED_FALLBACK;
			gen_q          <= SEED_FALLBACK;
			slow_q         <= '0;
			mid_q          <= '0;
			fast_q         <= '0;
			busy_q         <= 1'b0;
			pc_q           <= '0;
			result_valid_q <= 1'b0;
		end else begin
			// a new word may replace one taken at the same edge
			if (advance && word.done)
				result_valid_q <= 1'b1;
			else if (result_valid_q && !result_stall)
				result_valid_q <= 1'b0;
			if (cfg_wr) begin
				case (cfg_index)
					CFG_MODE: mode_q <= cfg_data[0];
					CFG_SEED: begin
						seed_q <= cfg_data;
						gen_q  <= wr_seed_eff;
						slow_q <= '0;
						mid_q  <= '0;
						fast_q <= '0;
					end
					default: ;
				endcase
			end else if (accept) begin
				busy_q <= 1'b1;
				pc_q   <= '0;
				gen_q  <= gen_next;
				if (restart) begin
					slow_q <= '0;
					mid_q  <= '0;
					fast_q <= '0;
				end
			end else if (advance) begin
				case (word.ret)
					RET_SAT_SLOW: slow_q <= sat_val;
					RET_SAT_MID:  mid_q  <= sat_val;
					RET_SAT_FAST: fast_q <= sat_val;
					default: ;
				endcase
				if (word.jmp_white && !mode_q) begin
					pc_q <= PC_WHITE;
				end else if (word.done) begin
					busy_q <= 1'b0;
				end else begin
					pc_q <= pc_q + 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (advance && word.ret == RET_LOAD_T)
			t_q <= mul_res;
		if (advance && word.ret == RET_SUM)
			sum_q <= sum_d;
		if (advance && word.done)
			sample_q <= out_val;
	end

	// a product issued by the microcode comes back through the v_s1 and v_s2 valid registers
	a_mul_latency: assert property (@(posedge clk) disable iff (!arst_n)
		mul_issue |-> ##2 mul_valid)
		else $error("multiplier result not back two cycles after issue");

	// every retire step that loads, saturates or sums a product finds one waiting
	a_retire_has_product: assert property (@(posedge clk) disable iff (!arst_n)
		(busy_q && (word.ret == RET_LOAD_T || word.ret == RET_SAT_SLOW ||
			word.ret == RET_SAT_MID || word.ret == RET_SAT_FAST ||
			word.ret == RET_SUM)) |-> mul_valid)
		else $error("retire step without a multiplier result");

	// a new word appears only from a completing done step
	a_word_from_done: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(result_valid_q) |-> $past(busy_q && word.done))
		else $error("result word raised outside a done step");

	// a step short of the last never raises a word
	a_no_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(busy_q && !word.done) |=> !$rose(result_valid_q) || !busy_q)
		else $error("word delivered while the program was mid-way");

endmodule
